// ===== hdl/crwm_pkg.sv =====
// Shared types and constants for the core and rope word memory.
package crwm_pkg;

    // Field widths of one transaction
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 16;
    localparam int ERASABLE_W = 15;
    localparam int S_TDATA_W  = 40;   // cmd + addr + data = 34 bits, padded to bytes
    localparam int M_TDATA_W  = 24;   // read_data + parity_ok = 17 bits, padded

    // Bit positions inside the stream words
    localparam int S_CMD_LSB  = 0;
    localparam int S_ADDR_LSB = S_CMD_LSB + CMD_W;
    localparam int S_DATA_LSB = S_ADDR_LSB + ADDR_W;
    localparam int M_POK_BIT  = DATA_W;

    // Access kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_RD_ERASABLE = 2'd0,
        CMD_WR_ERASABLE = 2'd1,
        CMD_RD_FIXED    = 2'd2,
        CMD_WR_FIXED    = 2'd3
    } cmd_t;

    // Power-up sequencing
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } clr_state_t;

    // Side information that travels with a memory access
    typedef struct packed {
        cmd_t cmd;
        logic hit;   // address selects a real, writable cell of its store
    } acc_meta_t;

endpackage

// ===== hdl/crwm_ram.sv =====
// Single-port synchronous RAM, read-first, registered read data.
module crwm_ram
    import crwm_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Old contents come out, new contents go in, same cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/crwm_result.sv =====
// Result stage: formats the word read, works out parity, holds the output register.
module crwm_result
    import crwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  issue,       // access started this cycle
    input  acc_meta_t             issue_meta,
    input  logic [ERASABLE_W-1:0] er_q,
    input  logic [DATA_W-1:0]     fx_q,
    output logic                  issue_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata      // [15:0] read_data, [16] parity_ok
);

    logic                 b_valid_reg, b_valid_next;
    acc_meta_t            b_meta_reg;
    logic                 c_valid_reg, c_valid_next;
    logic [DATA_W-1:0]    c_rd_reg;
    logic                 c_pok_reg;
    logic                 c_ready;
    logic                 b_adv;
    logic [DATA_W-1:0]    fx_raw;
    logic [DATA_W-1:0]    rd_next;
    logic                 pok_next;

    // Handshake between the read stage and the output register
    assign c_ready     = !c_valid_reg || m_tready;
    assign b_adv       = b_valid_reg && c_ready;
    assign issue_ready = !b_valid_reg || c_ready;

    assign b_valid_next = issue || (b_valid_reg && !c_ready);
    assign c_valid_next = b_adv || (c_valid_reg && !m_tready);

    // Word formatting: sign duplicated, fixed parity bit dropped
    always_comb
    begin
        fx_raw   = b_meta_reg.hit ? fx_q : '0;
        rd_next  = '0;
        pok_next = 1'b0;
        case (b_meta_reg.cmd)
            CMD_RD_ERASABLE:
            begin
                if (b_meta_reg.hit)
                begin
                    rd_next = {er_q[ERASABLE_W-1], er_q};
                end
            end
            CMD_RD_FIXED:
            begin
                rd_next  = {fx_raw[DATA_W-1], fx_raw[DATA_W-1], fx_raw[DATA_W-3:0]};
                pok_next = ^fx_raw;
            end
            default:
            begin
                rd_next  = '0;
                pok_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_meta_reg <= issue_meta;
        end
        if (b_adv)
        begin
            c_rd_reg  <= rd_next;
            c_pok_reg <= pok_next;
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - 1){1'b0}}, c_pok_reg, c_rd_reg};

endmodule

// ===== hdl/core_and_rope_word_memory.sv =====
// Top level of the core and rope word memory: clearing sequencer, stores, result stage.
//
// One access per transaction on the slave stream (s_tvalid/s_tready/s_tdata):
// read erasable (destructive), write erasable, read fixed, write raw fixed.
// Each access gives exactly one transaction on the master stream
// (m_tvalid/m_tready/m_tdata) carrying read_data and parity_ok, in order.
// An accepted access passes the read stage and then the output register before
// m_tvalid; one access per cycle is sustained while the receiver does not stall,
// set by the single read-first port of each store, which reads and writes back
// (clears) an erasable cell in the same cycle. After reset both stores are swept
// to zero, one word of each per cycle, until every address of the larger store
// (36864 words with the defaults) is cleared; s_tready stays low during the sweep.
// When the receiver stalls, the output register holds its transaction and one
// further result waits in the read stage; s_tready drops only once both are
// full, so no transaction is lost or repeated.
// Erasable addresses at or above ERASABLE_DEPTH and ZERO_ADDRESS read 0 and
// ignore writes; fixed addresses at or above FIXED_DEPTH read 0 with
// parity_ok 0 and ignore writes.
module core_and_rope_word_memory
    import crwm_pkg::*;
#(
    parameter int ERASABLE_DEPTH = 2048,
    parameter int FIXED_DEPTH    = 36864,
    parameter int ZERO_ADDRESS   = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] cmd, [17:2] addr, [33:18] data
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [15:0] read_data, [16] parity_ok
);

    localparam int EA_W      = $clog2(ERASABLE_DEPTH);
    localparam int FA_W      = $clog2(FIXED_DEPTH);
    localparam int CLR_DEPTH = (ERASABLE_DEPTH > FIXED_DEPTH) ? ERASABLE_DEPTH : FIXED_DEPTH;
    localparam int CNT_W     = $clog2(CLR_DEPTH);

    clr_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  clearing;
    logic                  clr_last;

    cmd_t                  s_cmd;
    logic [ADDR_W-1:0]     s_addr;
    logic [DATA_W-1:0]     s_data;
    logic                  accept;
    logic                  issue_ready;
    logic                  er_hit;
    logic                  fx_hit;
    acc_meta_t             issue_meta;

    logic                  er_en, er_we;
    logic [EA_W-1:0]       er_addr;
    logic [ERASABLE_W-1:0] er_wdata, er_q;
    logic                  fx_en, fx_we;
    logic [FA_W-1:0]       fx_addr;
    logic [DATA_W-1:0]     fx_wdata, fx_q;

    // Unpack the slave transaction
    assign s_cmd  = cmd_t'(s_tdata[S_CMD_LSB +: CMD_W]);
    assign s_addr = s_tdata[S_ADDR_LSB +: ADDR_W];
    assign s_data = s_tdata[S_DATA_LSB +: DATA_W];

    // Clearing sequencer: next state
    assign clr_last = (clr_cnt_reg == CNT_W'(CLR_DEPTH - 1));

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    state_next   = ST_RUN;
                    clr_cnt_next = '0;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next   = ST_CLEAR;
                clr_cnt_next = '0;
            end
        endcase
    end

    // Clearing sequencer: outputs
    always_comb
    begin
        case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Acceptance and address decode
    assign s_tready = !clearing && issue_ready;
    assign accept   = s_tvalid && s_tready;

    assign er_hit = ({1'b0, s_addr} < (ADDR_W+1)'(ERASABLE_DEPTH))
                    && (s_addr != ADDR_W'(ZERO_ADDRESS));
    assign fx_hit = ({1'b0, s_addr} < (ADDR_W+1)'(FIXED_DEPTH));

    always_comb
    begin
        issue_meta.cmd = s_cmd;
        case (s_cmd)
            CMD_RD_ERASABLE, CMD_WR_ERASABLE: issue_meta.hit = er_hit;
            CMD_RD_FIXED, CMD_WR_FIXED:       issue_meta.hit = fx_hit;
            default:                          issue_meta.hit = 1'b0;
        endcase
    end

    // Erasable store port: sweep, destructive read or write
    always_comb
    begin
        if (clearing)
        begin
            er_en    = 1'b0;
            er_we    = ({1'b0, clr_cnt_reg} < (CNT_W+1)'(ERASABLE_DEPTH));
            er_addr  = clr_cnt_reg[EA_W-1:0];
            er_wdata = '0;
        end
        else
        begin
            er_en    = accept && (s_cmd == CMD_RD_ERASABLE);
            er_we    = accept && er_hit
                       && ((s_cmd == CMD_RD_ERASABLE) || (s_cmd == CMD_WR_ERASABLE));
            er_addr  = s_addr[EA_W-1:0];
            er_wdata = (s_cmd == CMD_WR_ERASABLE) ? s_data[ERASABLE_W-1:0] : '0;
        end
    end

    // Fixed store port: sweep, read or raw write
    always_comb
    begin
        if (clearing)
        begin
            fx_en    = 1'b0;
            fx_we    = ({1'b0, clr_cnt_reg} < (CNT_W+1)'(FIXED_DEPTH));
            fx_addr  = clr_cnt_reg[FA_W-1:0];
            fx_wdata = '0;
        end
        else
        begin
            fx_en    = accept && (s_cmd == CMD_RD_FIXED);
            fx_we    = accept && fx_hit && (s_cmd == CMD_WR_FIXED);
            fx_addr  = s_addr[FA_W-1:0];
            fx_wdata = s_data;
        end
    end

    crwm_ram #(
        .WIDTH (ERASABLE_W),
        .DEPTH (ERASABLE_DEPTH)
    ) u_erasable (
        .clk   (clk),
        .en    (er_en),
        .we    (er_we),
        .addr  (er_addr),
        .wdata (er_wdata),
        .rdata (er_q)
    );

    crwm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FIXED_DEPTH)
    ) u_fixed (
        .clk   (clk),
        .en    (fx_en),
        .we    (fx_we),
        .addr  (fx_addr),
        .wdata (fx_wdata),
        .rdata (fx_q)
    );

    crwm_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (accept),
        .issue_meta  (issue_meta),
        .er_q        (er_q),
        .fx_q        (fx_q),
        .issue_ready (issue_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== hdl/crwm_checker.sv =====
// Port-level checks for the core and rope word memory, bound to the top level.
module crwm_checker
    import crwm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // Every transaction taken must show a result on m_tvalid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result missing after accepted transaction");

    // Sign is always duplicated into the top two bits of read_data
    a_sign_dup: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DATA_W-1] == m_tdata[DATA_W-2]))
        else $error("sign bits of read_data differ");

    // Padding bits above parity_ok stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:M_POK_BIT+1] == '0))
        else $error("padding bits of m_tdata set");

    // The stores are being swept right after reset, so nothing is taken
    a_sweep_block: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("transaction taken during clearing sweep");

endmodule

bind core_and_rope_word_memory crwm_checker u_crwm_checker (.*);
